[design/signed_int_to_decimal_ascii_defines.svh]
// Assertion macros shared by the integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SITDA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SITDA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sitda_pkg.sv]
// Types, constants and helpers for the integer to decimal text converter.
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Emitter sequencer states
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SIGN,
        EM_DIGIT
    } sitda_em_state_t;

    // Converted number handed from the converter to the emitter
    typedef struct packed {
        logic               done;
        logic               neg;
        logic [BCD_W-1:0]   bcd;
    } sitda_bcd_t;

    // Add three to every BCD digit of five or more, ahead of the next shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd[4*i +: 4];
            if (d >= 4'd5) begin
                res[4*i +: 4] = 4'(d + 4'd3);
            end
        end
        return res;
    endfunction

endpackage

[design/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per item.
//
//  channel | direction | ports                                  | item
//  s_      | in        | s_valid s_ready s_value[31:0]          | one signed integer
//  m_      | out       | m_valid m_ready m_ascii_char m_last_char | one character
//
// An integer is taken, bit-serial shift and add three over all 32 bits builds
// ten BCD digits, they are handed over, leading zeros are dropped one per
// cycle (up to 9), and the characters (optional '-', 1 to 10 digits) leave
// one per cycle while m_ready is high. A new integer is taken only once the
// previous one is through.
// Reset is synchronous, active low, and clears only control state.
// A stalled m_ready holds the sequencer; the next integer is taken as soon as
// the last character sits in the output register.
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_ascii_char,
    output logic                m_last_char
);
    import sitda_pkg::*;

    logic        dab_busy;
    logic        emit_busy;
    logic        start;
    sitda_bcd_t  dab_res;

    // Only one item in flight
    assign s_ready = !dab_busy && !emit_busy;
    assign start   = s_valid && s_ready;

    // Binary to BCD
    sitda_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .value   ($unsigned(s_value)),
        .busy    (dab_busy),
        .res     (dab_res)
    );

    // Character output
    sitda_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res          (dab_res),
        .busy         (emit_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last_char  (m_last_char)
    );

    // Converter hands over only to an idle emitter
    `SITDA_ASSERT_SAME(a_handover_idle, aclk, aresetn, dab_res.done, !emit_busy,
        "BCD result ready while emitter busy")
    // No second item directly after one is taken
    `SITDA_ASSERT_NEXT(a_single_item, aclk, aresetn, start, !s_ready,
        "input accepted twice in a row")
    // The sign is never the final character
    `SITDA_ASSERT_SAME(a_sign_not_last, aclk, aresetn,
        m_valid && m_ascii_char == CHAR_MINUS, !m_last_char,
        "minus sign flagged as last character")
    // Every character is a digit or the minus sign
    `SITDA_ASSERT_SAME(a_char_legal, aclk, aresetn, m_valid,
        (m_ascii_char == CHAR_MINUS) ||
        (m_ascii_char >= CHAR_ZERO && m_ascii_char <= 8'h39),
        "illegal output character")

endmodule

[design/sitda_dabble.sv]
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module sitda_dabble (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 value,
    output logic                        busy,
    output sitda_pkg::sitda_bcd_t       res
);
    import sitda_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [SHIFT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0]      mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_adj;

    // Digits corrected ahead of the next shift
    assign bcd_adj = bcd_adjust(bcd_reg);

    // Load the magnitude, then shift it into the BCD register MSB first
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next  = value[VALUE_W-1];
            cnt_next  = '0;
            mag_next  = value[VALUE_W-1] ? VALUE_W'(~value + 32'd1) : value;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = SHIFT_CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == SHIFT_CNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign busy     = busy_reg | done_reg;
    assign res.done = done_reg;
    assign res.neg  = neg_reg;
    assign res.bcd  = bcd_reg;

endmodule

[design/sitda_emit.sv]
// Character emitter: drops leading zeros, adds the sign, sends one digit a cycle while the output is free.
module sitda_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sitda_pkg::sitda_bcd_t       res,
    output logic                        busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_ascii_char,
    output logic                        m_last_char
);
    import sitda_pkg::*;

    sitda_em_state_t     state_reg, state_next;
    logic [BCD_W-1:0]    dig_reg, dig_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                valid_reg, valid_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;
    logic                out_free;
    logic [3:0]          top_digit;

    assign top_digit = dig_reg[BCD_W-1 -: 4];
    assign out_free  = !valid_reg || m_ready;

    // Sequencer and output register loading
    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !m_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            EM_IDLE: begin
                if (res.done) begin
                    dig_next   = res.bcd;
                    rem_next   = REM_W'(NUM_DIGITS);
                    neg_next   = res.neg;
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP: begin
                // one leading zero dropped per cycle, keeping at least one digit
                if (top_digit == 4'd0 && rem_reg > REM_W'(1)) begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    rem_next = REM_W'(rem_reg - 1'b1);
                end else begin
                    state_next = neg_reg ? EM_SIGN : EM_DIGIT;
                end
            end
            EM_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + {4'd0, top_digit};
                    last_next  = (rem_reg == REM_W'(1));
                    dig_next   = {dig_reg[BCD_W-5:0], 4'd0};
                    rem_next   = REM_W'(rem_reg - 1'b1);
                    if (rem_reg == REM_W'(1)) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        dig_reg  <= dig_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy         = (state_reg != EM_IDLE);
    assign m_valid      = valid_reg;
    assign m_ascii_char = char_reg;
    assign m_last_char  = last_reg;

endmodule
